### rtl/core/md5_pkg.sv
`timescale 1ns / 1ps
// MD5 digest engine: shared types, constants and round helpers.
// Used by every module in rtl/core; depends on nothing.
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } md5_out_t;

  typedef struct packed {
    logic [31:0] word;
    logic        blk_last;
    logic        msg_last;
  } md5_word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MARK,
    F_ZERO,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_FINAL
  } core_state_t;

  typedef struct packed {
    core_state_t state;
    logic [3:0]  widx;
  } core_status_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] BLK_LAST  = 6'h3F;
  localparam logic [5:0] ROUND_END = 6'd63;
  localparam logic [3:0] WORD_LAST = 4'd15;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] k;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    k = r;
      2'd1:    k = 4'(r * 4'd5 + 4'd1);
      2'd2:    k = 4'(r * 4'd3 + 4'd5);
      default: k = 4'(r * 4'd7);
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, s};
    return (v << s) | (v >> rs);
  endfunction

endpackage

### rtl/core/md5_message_digest.sv
`timescale 1ns / 1ps
// MD5 message digest engine, top level.
// Depends on md5_pkg, md5_front, md5_fifo and md5_core.
//
// Usage: push one request per message step on in_item (a byte with byte_valid,
// and/or message_end). A request is taken when in_push is high and in_full is
// low. Bytes are taken one per cycle while the word queue has room; a full
// 64-byte block is compressed in 64 rounds of the single round unit and then
// finalized; the round unit and the four-word queue that hides its busy time
// set the sustained input rate.
// After message_end, in_full stays high while 9 to 72 pad and length bytes are
// generated, one per cycle while the word queue has room; the digest appears
// once the core has compressed and finalized the last block. The digest is held on
// out_item while out_empty is low and is removed by out_pop. A waiting digest
// does not block new input: the next message streams in and compresses, and
// only its own finalize waits for the output register to be popped.
// Reset (rst_n low at a clock edge) loads the initial chaining values, clears
// the bit count and the queue, and drops any waiting digest.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  md5_in_t  in_item,
  output logic     in_full,
  output md5_out_t out_item,
  output logic     out_empty,
  input  logic     out_pop
);

  logic         fifo_full;
  logic         fifo_empty;
  logic         fifo_wr;
  logic         fifo_pop;
  md5_word_t    fifo_wdata;
  md5_word_t    fifo_rdata;
  core_status_t core_st;

  md5_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .fifo_full  (fifo_full),
    .fifo_wr    (fifo_wr),
    .fifo_wdata (fifo_wdata)
  );

  md5_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fifo_wr),
    .wr_data (fifo_wdata),
    .full    (fifo_full),
    .rd_en   (fifo_pop),
    .rd_data (fifo_rdata),
    .empty   (fifo_empty)
  );

  md5_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_rdata (fifo_rdata),
    .fifo_pop   (fifo_pop),
    .out_item   (out_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .status     (core_st)
  );

  a_msg_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr && fifo_wdata.msg_last |-> fifo_wdata.blk_last)
    else $error("message end word does not close a block");

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_item.message_end |=> in_full)
    else $error("input not held off during padding");

  a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop && !fifo_empty && fifo_rdata.blk_last |-> core_st.widx == WORD_LAST)
    else $error("block end word not at word index 15");

  a_digest_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(core_st.state == B_FINAL))
    else $error("digest appeared outside finalize");

endmodule

### rtl/core/md5_front.sv
`timescale 1ns / 1ps
// MD5 front end: takes message bytes, appends padding and length, packs words.
// Depends on md5_pkg; feeds md5_fifo.
module md5_front
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  md5_in_t   in_item,
  output logic      in_full,
  input  logic      fifo_full,
  output logic      fifo_wr,
  output md5_word_t fifo_wdata
);

  front_state_t state_r, state_nxt;
  logic [63:0]  bit_count_r;
  logic [63:0]  len_r;
  logic [31:0]  word_r;
  logic [5:0]   pos;
  logic         in_acc;
  logic         push_en;
  logic [7:0]   push_byte;
  logic         len_done;

  assign pos      = bit_count_r[8:3];
  assign in_full  = (state_r != F_IDLE) || fifo_full;
  assign in_acc   = in_push && !in_full;
  assign len_done = (state_r == F_LEN) && push_en && (pos == BLK_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_acc && in_item.message_end) state_nxt = F_MARK;
      end
      F_MARK, F_ZERO: begin
        if (!fifo_full) state_nxt = (6'(pos + 6'd1) == LEN_POS) ? F_LEN : F_ZERO;
      end
      F_LEN: begin
        if (!fifo_full && pos == BLK_LAST) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'd0;
    case (state_r)
      F_IDLE: begin
        push_en   = in_acc && in_item.byte_valid;
        push_byte = in_item.data_byte;
      end
      F_MARK: begin
        push_en   = !fifo_full;
        push_byte = PAD_BYTE;
      end
      F_ZERO: begin
        push_en   = !fifo_full;
        push_byte = 8'd0;
      end
      F_LEN: begin
        push_en   = !fifo_full;
        push_byte = len_r[{pos[2:0], 3'b000} +: 8];
      end
      default: begin
        push_en   = 1'b0;
        push_byte = 8'd0;
      end
    endcase
  end

  assign fifo_wr             = push_en && (pos[1:0] == 2'd3);
  assign fifo_wdata.word     = {push_byte, word_r[31:8]};
  assign fifo_wdata.blk_last = (pos == BLK_LAST);
  assign fifo_wdata.msg_last = (pos == BLK_LAST) && (state_r == F_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      bit_count_r <= 64'd0;
    end else begin
      state_r <= state_nxt;
      if (len_done) begin
        bit_count_r <= 64'd0;
      end else if (push_en) begin
        bit_count_r <= bit_count_r + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      word_r <= {push_byte, word_r[31:8]};
    end
    if (state_r == F_IDLE && in_acc && in_item.message_end) begin
      len_r <= in_item.byte_valid ? bit_count_r + 64'd8 : bit_count_r;
    end
  end

endmodule

### rtl/core/md5_fifo.sv
`timescale 1ns / 1ps
// Short word queue between the MD5 front end and the compression core.
// Depends on md5_pkg for the entry type and depth.
module md5_fifo
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  md5_word_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output md5_word_t rd_data,
  output logic      empty
);

  md5_word_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]       wptr_r;
  logic [FIFO_AW-1:0]       rptr_r;
  logic [FIFO_AW:0]         cnt_r;
  logic                     do_wr;
  logic                     do_rd;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + FIFO_AW'(1);
      if (do_rd) rptr_r <= rptr_r + FIFO_AW'(1);
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

endmodule

### rtl/core/md5_core.sv
`timescale 1ns / 1ps
// MD5 compression core: loads 16 words, runs 64 rounds, finalizes and holds the digest.
// Depends on md5_pkg; reads words from md5_fifo.
module md5_core
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fifo_empty,
  input  md5_word_t    fifo_rdata,
  output logic         fifo_pop,
  output md5_out_t     out_item,
  output logic         out_empty,
  input  logic         out_pop,
  output core_status_t status
);

  core_state_t state_r, state_nxt;
  logic [31:0] w_r [16];
  logic [3:0]  widx_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  md5_out_t    out_r;
  logic        out_valid_r;
  logic        out_take;
  logic        round_en;
  logic        final_en;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] new_b;
  logic [31:0] s_a, s_b, s_c, s_d;

  assign out_take  = out_pop && out_valid_r;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign status    = '{state: state_r, widx: widx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_LOAD: begin
        if (!fifo_empty && fifo_rdata.blk_last) state_nxt = B_ROUND;
      end
      B_ROUND: begin
        if (rnd_r == ROUND_END) state_nxt = B_FINAL;
      end
      B_FINAL: begin
        if (!fin_r || !out_valid_r || out_take) state_nxt = B_LOAD;
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  always_comb begin
    fifo_pop = 1'b0;
    round_en = 1'b0;
    final_en = 1'b0;
    case (state_r)
      B_LOAD:  fifo_pop = !fifo_empty;
      B_ROUND: round_en = 1'b1;
      B_FINAL: final_en = !fin_r || !out_valid_r || out_take;
      default: begin
        fifo_pop = 1'b0;
        round_en = 1'b0;
        final_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + f + w_r[msg_index(rnd_r)] + ROUND_K[rnd_r];
    new_b = rotl32(sum, ROT_S[{rnd_r[5:4], rnd_r[1:0]}]) + b_r;
  end

  assign s_a = ch_a_r + a_r;
  assign s_b = ch_b_r + b_r;
  assign s_c = ch_c_r + c_r;
  assign s_d = ch_d_r + d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_LOAD;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
      ch_a_r      <= INIT_A;
      ch_b_r      <= INIT_B;
      ch_c_r      <= INIT_C;
      ch_d_r      <= INIT_D;
    end else begin
      state_r <= state_nxt;
      if (fifo_pop) widx_r <= widx_r + 4'd1;
      if (final_en) begin
        if (fin_r) begin
          ch_a_r <= INIT_A;
          ch_b_r <= INIT_B;
          ch_c_r <= INIT_C;
          ch_d_r <= INIT_D;
        end else begin
          ch_a_r <= s_a;
          ch_b_r <= s_b;
          ch_c_r <= s_c;
          ch_d_r <= s_d;
        end
      end
      if (final_en && fin_r) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      w_r[widx_r] <= fifo_rdata.word;
      if (fifo_rdata.blk_last) begin
        fin_r <= fifo_rdata.msg_last;
        rnd_r <= '0;
        a_r   <= ch_a_r;
        b_r   <= ch_b_r;
        c_r   <= ch_c_r;
        d_r   <= ch_d_r;
      end
    end
    if (round_en) begin
      a_r   <= d_r;
      d_r   <= c_r;
      c_r   <= b_r;
      b_r   <= new_b;
      rnd_r <= rnd_r + 6'd1;
    end
    if (final_en && fin_r) begin
      out_r.digest_low  <= {s_b, s_a};
      out_r.digest_high <= {s_d, s_c};
    end
  end

endmodule
